>>> rtl/core/assert_macros.svh
// shared assertion macros, sampled on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/core/mdbu_pkg.sv
// ----------------------------------------------------------------------------
// mdbu_pkg
// Shared widths, constants and helpers for the mic dc-block / decimate /
// mu-law encoder.
// ----------------------------------------------------------------------------
package mdbu_pkg;

  localparam int RAW_W       = 16;
  localparam int SAMPLE_W    = 12;
  localparam int DC_W        = 20;
  localparam int GAIN_W      = 3;
  localparam int ULAW_W      = 8;
  localparam int SCALE_SHIFT = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DC_W-1:0]   DC_RESET   = DC_W'(2048 << 8);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1);

  // signed width of a sum of dec dc-removed samples, each within +-4095
  function automatic int sum_width(input int dec);
    return $clog2(dec * (1 << SAMPLE_W)) + 1;
  endfunction

endpackage

>>> rtl/core/mic_dc_block_decimate_ulaw.sv
// ----------------------------------------------------------------------------
// mic_dc_block_decimate_ulaw
// Microphone front end: dc removal, decimation by averaging and mu-law
// encoding of the average into one byte.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_stall_o   raw_word_i [15:0]
//   out      out  out_valid_o/out_stall_i ulaw_byte_o [7:0]
//   cfg      in   cfg_we_i                cfg_wdata_i [2:0] (gain shift)
//
// one converter word is taken every cycle unless the front stalls; every
// DECIMATION-th word yields a byte, registered after the reciprocal multiply
// and again after the encode; the front stalls only when the two-entry sum
// queue is full and the word would close a block; the back drains the queue
// at one sum per cycle unless the output stalls; reset clears the dc tracker
// to mid-scale, the sum and the count, and sets the gain shift to 1
// ----------------------------------------------------------------------------
module mic_dc_block_decimate_ulaw import mdbu_pkg::*; #(
  parameter int DECIMATION = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [RAW_W-1:0]  raw_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ULAW_W-1:0] ulaw_byte_o,
  input  logic              cfg_we_i,
  input  logic [GAIN_W-1:0] cfg_wdata_i
);

  localparam int SUM_W = sum_width(DECIMATION);

  logic             push;
  logic [SUM_W-1:0] push_data;
  logic             full;
  logic             pop;
  logic [SUM_W-1:0] pop_data;
  logic             empty;

  mdbu_front #(
    .DECIMATION (DECIMATION)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_word_i  (raw_word_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  mdbu_queue #(
    .WIDTH (SUM_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  mdbu_back #(
    .DECIMATION (DECIMATION)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ulaw_byte_o (ulaw_byte_o)
  );

endmodule

>>> rtl/core/mdbu_front.sv
// ----------------------------------------------------------------------------
// mdbu_front
// Input side: dc tracker, running sum of dc-removed samples and decimation
// count. Every DECIMATION-th sample pushes the finished sum to the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdbu_front import mdbu_pkg::*; #(
  parameter int DECIMATION = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [RAW_W-1:0]                  raw_word_i,
  output logic                              push_o,
  output logic [sum_width(DECIMATION)-1:0]  push_data_o,
  input  logic                              full_i
);

  localparam int SUM_W = sum_width(DECIMATION);
  localparam int CNT_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int HI_W  = DC_W - 8;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DECIMATION - 1);
  localparam logic [DC_W-1:0]  DC_MAX   = DC_W'(4095 * 256);

  logic [DC_W-1:0]         dc_q, dc_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        count_q, count_d;

  logic [SAMPLE_W-1:0]     adc;
  logic                    lo_nz;
  logic signed [DC_W+1:0]  dc_new;
  logic signed [SAMPLE_W:0] smp;
  logic signed [SUM_W-1:0] sum_new;
  logic                    accept;
  logic                    last;

  assign adc   = raw_word_i[SAMPLE_W-1:0];
  assign lo_nz = (dc_q[7:0] != 8'd0);

  // dc += floor((adc*256 - dc) / 256) = dc + adc - dc[19:8] - (dc[7:0] != 0)
  assign dc_new = $signed({2'b00, dc_q})
                + $signed({{(DC_W+2-SAMPLE_W){1'b0}}, adc})
                - $signed({{(DC_W+2-HI_W){1'b0}}, dc_q[DC_W-1:8]})
                - $signed({{(DC_W+1){1'b0}}, lo_nz});

  assign smp     = $signed({1'b0, adc}) - $signed({1'b0, dc_new[DC_W-1:8]});
  assign sum_new = sum_q + SUM_W'(smp);

  assign last       = (count_q == CNT_LAST);
  assign in_stall_o = full_i && last;
  assign accept     = in_valid_i && !in_stall_o;

  assign push_o      = accept && last;
  assign push_data_o = sum_new;

  always_comb begin
    dc_d    = dc_q;
    sum_d   = sum_q;
    count_d = count_q;
    if (accept) begin
      dc_d = dc_new[DC_W-1:0];
      if (last) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_new;
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q    <= DC_RESET;
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      dc_q    <= dc_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  `ASSERT_ALWAYS(a_dc_range, dc_q <= DC_MAX, "dc estimate left the sample range")
  `ASSERT_ALWAYS(a_count_range, count_q <= CNT_LAST, "decimation count overran")

endmodule

>>> rtl/core/mdbu_queue.sv
// ----------------------------------------------------------------------------
// mdbu_queue
// Short queue of finished sums between the front and back halves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdbu_queue import mdbu_pkg::*; #(
  parameter int WIDTH = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == CNT_FULL);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into a full queue")
  `ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "pop from an empty queue")

endmodule

>>> rtl/core/mdbu_back.sv
// ----------------------------------------------------------------------------
// mdbu_back
// Output side: divide the sum by DECIMATION through a reciprocal multiply,
// scale by the gain, saturate and mu-law encode into the output register.
// ----------------------------------------------------------------------------
module mdbu_back import mdbu_pkg::*; #(
  parameter int DECIMATION = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [GAIN_W-1:0]                 cfg_wdata_i,
  input  logic                              empty_i,
  input  logic [sum_width(DECIMATION)-1:0]  pop_data_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ULAW_W-1:0]                 ulaw_byte_o
);

  localparam int SUM_W   = sum_width(DECIMATION);
  localparam int MAG_W   = SUM_W - 1;
  localparam int DIV_L   = (DECIMATION > 1) ? $clog2(DECIMATION) : 0;
  localparam int DIV_SH  = MAG_W + DIV_L;
  localparam int RECIP_W = MAG_W + DIV_L + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << DIV_SH) + DECIMATION - 1) / DECIMATION;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  localparam int SH_W   = 4;
  localparam int WIDE_W = SAMPLE_W + SCALE_SHIFT + (1 << GAIN_W) - 1;
  localparam int MAG15  = 15;
  localparam logic [MAG15-1:0] ULAW_CLIP = MAG15'(32635);
  localparam logic [MAG15-1:0] ULAW_BIAS = MAG15'(16'h84);

  logic [GAIN_W-1:0]    gain_q;

  logic                 s1_valid_q;
  logic [SAMPLE_W-1:0]  s1_mag_q;
  logic                 s1_neg_q;
  logic                 out_valid_q;
  logic [ULAW_W-1:0]    out_byte_q, out_byte_d;

  logic                 out_ready;
  logic                 s1_ready;
  logic                 sum_neg;
  logic [SUM_W-1:0]     sum_abs;
  logic [PROD_W-1:0]    prod;
  logic [SAMPLE_W-1:0]  quot;

  logic [SH_W-1:0]      sh_amt;
  logic [WIDE_W-1:0]    scaled;
  logic [MAG15-1:0]     clipped;
  logic [MAG15-1:0]     biased;
  logic [2:0]           expo;
  logic [MAG15-1:0]     mant_src;
  logic                 sign;

  // pipeline moves whenever the slot ahead is free or being emptied
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign pop_o     = s1_ready && !empty_i;

  // truncating division: |sum| * ceil(2^sh / d) >> sh, then the sign back on
  assign sum_neg = pop_data_i[SUM_W-1];
  assign sum_abs = sum_neg ? SUM_W'(-$signed(pop_data_i)) : pop_data_i;
  assign prod    = PROD_W'(sum_abs[MAG_W-1:0]) * PROD_W'(RECIP);
  assign quot    = prod[DIV_SH +: SAMPLE_W];

  // saturation and the encoder clip fold into one clamp of the magnitude
  assign sh_amt  = SH_W'(SCALE_SHIFT) + SH_W'(gain_q);
  assign scaled  = WIDE_W'(s1_mag_q) << sh_amt;
  assign clipped = (scaled > WIDE_W'(ULAW_CLIP)) ? ULAW_CLIP : scaled[MAG15-1:0];
  assign biased  = clipped + ULAW_BIAS;
  assign sign    = s1_neg_q && (s1_mag_q != '0);

  always_comb begin
    expo = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (biased[7+i]) begin
        expo = 3'(i);
      end
    end
  end

  assign mant_src   = biased >> (SH_W'(expo) + SH_W'(3));
  assign out_byte_d = ~{sign, expo, mant_src[3:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
      if (s1_ready) begin
        s1_valid_q <= !empty_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_mag_q <= quot;
      s1_neg_q <= sum_neg;
    end
    if (out_ready && s1_valid_q) begin
      out_byte_q <= out_byte_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ulaw_byte_o = out_byte_q;

endmodule

>>> tb/sv/mdbu_ulaw_checker.sv
// ----------------------------------------------------------------------------
// mdbu_ulaw_checker
// Watches the word and byte channels of the mic front end. It tracks the dc
// level, the block sum and the gain, predicts each mu-law byte, and compares
// every byte transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module mdbu_ulaw_checker import mdbu_pkg::*; #(
  parameter int DECIMATION = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [RAW_W-1:0]  raw_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [ULAW_W-1:0] ulaw_byte_i,
  input  logic              cfg_we_i,
  input  logic [GAIN_W-1:0] cfg_wdata_i,
  output int                pending_o,
  output int                errors_o
);

  localparam int ULAW_BIAS = 'h84;
  localparam int ULAW_CLIP = 32635;
  localparam int PCM_MAX   = 32767;
  localparam int PCM_MIN   = -32768;

  logic [DC_W-1:0]    dc_level;
  logic signed [15:0] block_sum;
  int                 block_count;
  logic [GAIN_W-1:0]  gain_copy;
  logic [ULAW_W-1:0]  expected_codes [$];
  int                 mismatch_count = 0;

  function automatic logic [ULAW_W-1:0] mulaw_code(input int pcm);
    logic       sign;
    int         mag;
    int         b;
    logic [2:0] segment;
    logic [3:0] mantissa;
    sign = (pcm < 0);
    mag = sign ? -pcm : pcm;
    // the most negative value clips like any other large magnitude
    if (mag > ULAW_CLIP) mag = ULAW_CLIP;
    mag = mag + ULAW_BIAS;
    segment = '0;
    for (b = 8; b <= 14; b++) begin
      if (mag[b]) segment = 3'(b - 7);
    end
    mantissa = 4'(mag >> (segment + 3));
    return ~{sign, segment, mantissa};
  endfunction

  function automatic void take_word(input logic [RAW_W-1:0] word);
    int sample;
    int gap;
    int average;
    int scaled;
    sample = int'(word[SAMPLE_W-1:0]);
    gap = (sample << 8) - int'(dc_level);
    // arithmetic shift floors, so negative steps round down
    dc_level = DC_W'(int'(dc_level) + (gap >>> 8));
    block_sum = 16'(int'(block_sum) + sample - int'(dc_level >> 8));
    block_count++;
    if (block_count == DECIMATION) begin
      average = int'(block_sum) / DECIMATION;
      block_sum = '0;
      block_count = 0;
      scaled = average * (1 << (SCALE_SHIFT + gain_copy));
      if (scaled > PCM_MAX) scaled = PCM_MAX;
      else if (scaled < PCM_MIN) scaled = PCM_MIN;
      expected_codes.push_back(mulaw_code(scaled));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [ULAW_W-1:0] want;
    if (!rst_ni) begin
      dc_level = DC_RESET;
      block_sum = '0;
      block_count = 0;
      gain_copy = GAIN_RESET;
      expected_codes.delete();
    end else begin
      if (cfg_we_i) gain_copy = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: mu-law byte %h arrived with none expected", $time, ulaw_byte_i);
          mismatch_count++;
        end else begin
          want = expected_codes.pop_front();
          if (ulaw_byte_i !== want) begin
            $display("%0t: mu-law byte expected %h, got %h", $time, want, ulaw_byte_i);
            mismatch_count++;
          end
        end
      end
      // a byte is registered only after its last word is taken, so compare before predicting
      if (in_valid_i && !in_stall_i) take_word(raw_word_i);
    end
    pending_o <= expected_codes.size();
    errors_o <= mismatch_count;
  end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives converter words into the mic front end under random gaps and
// random output stalls, steps the gain shift through every value between
// phases, and forces one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench import mdbu_pkg::*; ();

  localparam int DECIMATION     = 3;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int IDLE_PCT       = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 60;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [RAW_W-1:0]  raw_word_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ULAW_W-1:0] ulaw_byte_o;
  logic              cfg_we_i;
  logic [GAIN_W-1:0] cfg_wdata_i;

  int pending_codes;
  int mismatches;
  int quiet_cycles;
  int hold_left;
  bit steady;
  bit hold_req;
  bit hold_ack;

  logic [GAIN_W-1:0] gain_plan [8] = '{3'd0, 3'd4, 3'd2, 3'd5, 3'd3, 3'd6, 3'd1, 3'd7};

  // mid-scale (zero out), ignored top bits, full-scale swings both ways
  logic [RAW_W-1:0] directed_words [21] = '{
    16'h0800, 16'h0800, 16'h0800, 16'hF800, 16'hF800, 16'hF800,
    16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0000, 16'hF000, 16'h0000,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7001, 16'h8FFE, 16'h0555,
    16'hAAAA, 16'h5555, 16'h1234
  };

  mic_dc_block_decimate_ulaw #(
    .DECIMATION (DECIMATION)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_word_i  (raw_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ulaw_byte_o (ulaw_byte_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  mdbu_ulaw_checker #(
    .DECIMATION (DECIMATION)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .raw_word_i  (raw_word_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .ulaw_byte_i (ulaw_byte_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending_codes),
    .errors_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [RAW_W-1:0] pick_word();
    logic [3:0] top_bits;
    int         roll;
    top_bits = 4'($urandom);
    roll = $urandom_range(99);
    if (roll < 50) return RAW_W'($urandom);
    // close to mid-scale, for small averages and the low segments
    if (roll < 75) return {top_bits, 12'(2048 + $urandom_range(64) - 32)};
    return {top_bits, ($urandom_range(1) ? 12'hFFF : 12'h000)};
  endfunction

  task automatic send_word(input logic [RAW_W-1:0] word);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_word_i <= word;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // wait for every predicted byte, then let a half-built block settle
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_codes != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] gain);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= gain;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    raw_word_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    steady <= 1'b0;
    hold_req <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // largest gain, so both saturation ends are reached
    write_gain('1);
    foreach (directed_words[i]) send_word(directed_words[i]);
    drain_and_settle();

    foreach (gain_plan[p]) begin
      write_gain(gain_plan[p]);
      // phase 2 backs up the input behind a long hold-off, phase 5 runs gap-free
      steady <= (p == 2 || p == 5);
      if (p == 2) hold_req <= ~hold_req;
      repeat (PHASE_WORDS) send_word(pick_word());
      drain_and_settle();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiving side
  initial begin
    out_stall_i <= 1'b0;
    hold_ack = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // no transfer on either channel for too long means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
